>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file of the text console.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset
`define TCW_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset
`define TCW_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication, also checked through reset
`define TCW_ASSERT_NXT_ALL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Types and constants of the text console: request codes, register indexes,
// field widths, controller states and the controller/datapath interface.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Field widths of the ports
  localparam int REQ_W      = 2;
  localparam int CHAR_W     = 8;
  localparam int IDX_W      = 12;
  localparam int ROW_CFG_W  = 6;
  localparam int COL_CFG_W  = 8;
  localparam int ATTR_W     = 8;
  localparam int CUR_ROW_W  = 5;
  localparam int CUR_COL_W  = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int CELL_W     = CHAR_W + ATTR_W;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_ROWS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_COLS    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TEXT_ATTRIBUTE = 2'd2;

  // Register reset values and special characters
  localparam logic [ROW_CFG_W-1:0] RESET_ROWS   = 6'd24;
  localparam logic [COL_CFG_W-1:0] RESET_COLS   = 8'd80;
  localparam logic [ATTR_W-1:0]    RESET_ATTR   = 8'd7;
  localparam logic [CHAR_W-1:0]    NEWLINE_CODE = 8'd10;

  // Request codes
  typedef enum logic [REQ_W-1:0] {
    REQ_PRINT = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_READ  = 2'd2
  } req_t;

  // Controller states
  typedef enum logic [3:0] {
    ST_BOOT_CLR,
    ST_IDLE,
    ST_EXEC,
    ST_SCR_INIT,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_SCR_ZERO,
    ST_CLR,
    ST_RESP
  } tcw_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;      // latch request, start cell read
    logic exec_print;  // print at cursor, update cursor
    logic home;        // cursor to 0,0
    logic ptr_clr;     // sweep pointer to 0
    logic scr_init;    // latch scroll extent
    logic scr_rd;      // read source cell of a scroll move
    logic scr_move;    // write moved cell at pointer
    logic zero_wr;     // write blank cell at pointer
    logic ptr_inc;     // advance sweep pointer
    logic load_out;    // load result word
  } tcw_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    req_t req;
    logic needs_scroll;
    logic move_more;
    logic zero_last;
    logic clr_last;
  } tcw_status_t;

endpackage

>>> rtl/text_console_writer_core.sv
// ----------------------------------------------------------------------------
// text_console_writer_core
// Text-mode console: a character-cell buffer with a cursor, serving print,
// clear and read requests, one result word per request.
// ----------------------------------------------------------------------------
// One request is handled at a time. A read, an unused code or a print that
// stays on screen loads its result word in the cycle after acceptance and
// then returns to idle for the next request word. A print that runs past
// the last row scrolls through the single cell RAM port pair: each moved
// cell is read and then written one row up, and the last row is blanked
// before the result word. A clear zeroes every cell, one per cycle. A
// stalled result word holds the next request in its response step until the
// word is taken. After reset a clearing pass over all MAX_ROWS*MAX_COLS
// cells (4096 by default) runs before the first request is taken; register
// writes are taken at any time.
// ----------------------------------------------------------------------------
module text_console_writer_core import tcw_pkg::*; #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 128
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [REQ_W-1:0]      in_req_type,
  input  logic [CHAR_W-1:0]     in_char_code,
  input  logic [IDX_W-1:0]      in_cell_index,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [CUR_ROW_W-1:0]  out_cursor_row,
  output logic [CUR_COL_W-1:0]  out_cursor_col,
  output logic [CHAR_W-1:0]     out_read_char,
  output logic [ATTR_W-1:0]     out_read_attr,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  tcw_cmd_t    cmd;
  tcw_status_t status;

  // Sequencer
  tcw_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Cell store and cursor
  tcw_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_req_type    (in_req_type),
    .in_char_code   (in_char_code),
    .in_cell_index  (in_cell_index),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .out_cursor_row (out_cursor_row),
    .out_cursor_col (out_cursor_col),
    .out_read_char  (out_read_char),
    .out_read_attr  (out_read_attr)
  );

endmodule

>>> rtl/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/tcw_ctrl.sv
// ----------------------------------------------------------------------------
// tcw_ctrl
// Sequencer of the text console: handshakes, request dispatch, scroll and
// clear sweeps, and the result word valid flag.
// ----------------------------------------------------------------------------
module tcw_ctrl import tcw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  output logic        out_valid,
  input  logic        out_stall,
  input  tcw_status_t status,
  output tcw_cmd_t    cmd
);

  tcw_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  // Result register can take a word this cycle
  assign out_free = !out_valid_r || !out_stall;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_BOOT_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_BOOT_CLR: begin
        cmd.zero_wr = 1'b1;
        cmd.ptr_inc = 1'b1;
        if (status.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (status.req)
          REQ_PRINT: begin
            cmd.exec_print = 1'b1;
            if (status.needs_scroll) begin
              state_nxt = ST_SCR_INIT;
            end else if (out_free) begin
              cmd.load_out = 1'b1;
              state_nxt    = ST_IDLE;
            end else begin
              state_nxt = ST_RESP;
            end
          end
          REQ_CLEAR: begin
            cmd.home    = 1'b1;
            cmd.ptr_clr = 1'b1;
            state_nxt   = ST_CLR;
          end
          default: begin
            if (out_free) begin
              cmd.load_out = 1'b1;
              state_nxt    = ST_IDLE;
            end else begin
              state_nxt = ST_RESP;
            end
          end
        endcase
      end
      ST_SCR_INIT: begin
        cmd.scr_init = 1'b1;
        cmd.ptr_clr  = 1'b1;
        state_nxt    = ST_SCR_RD;
      end
      ST_SCR_RD: begin
        if (status.move_more) begin
          cmd.scr_rd = 1'b1;
          state_nxt  = ST_SCR_WR;
        end else begin
          state_nxt = ST_SCR_ZERO;
        end
      end
      ST_SCR_WR: begin
        cmd.scr_move = 1'b1;
        cmd.ptr_inc  = 1'b1;
        state_nxt    = ST_SCR_RD;
      end
      ST_SCR_ZERO: begin
        cmd.zero_wr = 1'b1;
        cmd.ptr_inc = 1'b1;
        if (status.zero_last) begin
          state_nxt = ST_RESP;
        end
      end
      ST_CLR: begin
        cmd.zero_wr = 1'b1;
        cmd.ptr_inc = 1'b1;
        if (status.clr_last) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Result valid: set on load, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> rtl/tcw_datapath.sv
// ----------------------------------------------------------------------------
// tcw_datapath
// Datapath of the text console: registers, cursor, cell store, sweep
// pointer, address arithmetic and the result word.
// ----------------------------------------------------------------------------
module tcw_datapath import tcw_pkg::*; #(
  parameter int MAX_ROWS = 32,
  parameter int MAX_COLS = 128
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  tcw_cmd_t              cmd,
  output tcw_status_t           status,
  input  logic [REQ_W-1:0]      in_req_type,
  input  logic [CHAR_W-1:0]     in_char_code,
  input  logic [IDX_W-1:0]      in_cell_index,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic [CUR_ROW_W-1:0]  out_cursor_row,
  output logic [CUR_COL_W-1:0]  out_cursor_col,
  output logic [CHAR_W-1:0]     out_read_char,
  output logic [ATTR_W-1:0]     out_read_attr
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = AW + 1;
  localparam int RW    = $clog2(MAX_ROWS + 1);
  localparam int CW    = $clog2(MAX_COLS + 1);
  localparam int RCW   = $clog2(MAX_ROWS);
  localparam int CCW   = $clog2(MAX_COLS);
  localparam int RKW   = (ROW_CFG_W > RW) ? ROW_CFG_W : RW;
  localparam int CKW   = (COL_CFG_W > CW) ? COL_CFG_W : CW;
  localparam int XW    = ((AW > IDX_W) ? AW : IDX_W) + 1;

  logic [ROW_CFG_W-1:0] rows_cfg_r;
  logic [COL_CFG_W-1:0] cols_cfg_r;
  logic [ATTR_W-1:0]    attr_r;

  req_t                 req_r;
  logic [CHAR_W-1:0]    char_r;
  logic                 range_r;

  logic [RCW-1:0]       cur_row_r, cur_row_nxt;
  logic [CCW-1:0]       cur_col_r, cur_col_nxt;
  logic [PW-1:0]        ptr_r, ptr_nxt;
  logic [PW-1:0]        total_r;

  logic [RW-1:0]        rows_n;
  logic [CW-1:0]        cols_n;
  logic [RCW-1:0]       last_row, sat_row, row_new;
  logic [CCW-1:0]       last_col, sat_col, col_new;
  logic [CW-1:0]        col_inc;
  logic [RW-1:0]        row_inc;
  logic                 row_adv;
  logic                 needs_scroll;
  logic [PW-1:0]        lin;
  logic [PW-1:0]        src;
  logic                 in_range;

  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [CELL_W-1:0]    ram_wdata, ram_rdata;

  logic [CUR_ROW_W-1:0] out_row_r;
  logic [CUR_COL_W-1:0] out_col_r;
  logic [CHAR_W-1:0]    out_char_r;
  logic [ATTR_W-1:0]    out_attr_r;
  logic                 rd_hit;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_cfg_r <= RESET_ROWS;
      cols_cfg_r <= RESET_COLS;
      attr_r     <= RESET_ATTR;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_SCREEN_ROWS:    rows_cfg_r <= cfg_wdata[ROW_CFG_W-1:0];
        CFG_SCREEN_COLS:    cols_cfg_r <= cfg_wdata[COL_CFG_W-1:0];
        CFG_TEXT_ATTRIBUTE: attr_r     <= cfg_wdata[ATTR_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp geometry to 1..MAX
  always_comb begin
    if (rows_cfg_r == '0) begin
      rows_n = RW'(1);
    end else if (RKW'(rows_cfg_r) > RKW'(MAX_ROWS)) begin
      rows_n = RW'(MAX_ROWS);
    end else begin
      rows_n = RW'(rows_cfg_r);
    end
    if (cols_cfg_r == '0) begin
      cols_n = CW'(1);
    end else if (CKW'(cols_cfg_r) > CKW'(MAX_COLS)) begin
      cols_n = CW'(MAX_COLS);
    end else begin
      cols_n = CW'(cols_cfg_r);
    end
  end

  // Saturate cursor, then advance it for a print
  always_comb begin
    last_row     = RCW'(rows_n - RW'(1));
    last_col     = CCW'(cols_n - CW'(1));
    sat_row      = (RW'(cur_row_r) >= rows_n) ? last_row : cur_row_r;
    sat_col      = (CW'(cur_col_r) >= cols_n) ? last_col : cur_col_r;
    col_inc      = CW'(sat_col) + CW'(1);
    row_inc      = RW'(sat_row) + RW'(1);
    row_adv      = (char_r == NEWLINE_CODE) || (col_inc >= cols_n);
    needs_scroll = row_adv && (row_inc >= rows_n);
    col_new      = row_adv ? '0 : CCW'(col_inc);
    if (!row_adv) begin
      row_new = sat_row;
    end else if (needs_scroll) begin
      row_new = last_row;
    end else begin
      row_new = RCW'(row_inc);
    end
    lin = PW'(sat_row) * PW'(cols_n) + PW'(sat_col);
  end

  // Cursor update
  always_comb begin
    cur_row_nxt = cur_row_r;
    cur_col_nxt = cur_col_r;
    if (cmd.home) begin
      cur_row_nxt = '0;
      cur_col_nxt = '0;
    end else if (cmd.exec_print) begin
      cur_row_nxt = row_new;
      cur_col_nxt = col_new;
    end
  end

  // Sweep pointer
  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd.ptr_clr) begin
      ptr_nxt = '0;
    end else if (cmd.ptr_inc) begin
      ptr_nxt = ptr_r + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r <= '0;
      cur_col_r <= '0;
      ptr_r     <= '0;
    end else begin
      cur_row_r <= cur_row_nxt;
      cur_col_r <= cur_col_nxt;
      ptr_r     <= ptr_nxt;
    end
  end

  // Latch request and scroll extent
  assign in_range = XW'(in_cell_index) < XW'(DEPTH);

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      req_r   <= req_t'(in_req_type);
      char_r  <= in_char_code;
      range_r <= in_range;
    end
    if (cmd.scr_init) begin
      total_r <= PW'(rows_n) * PW'(cols_n);
    end
  end

  // Cell store ports
  assign src       = ptr_r + PW'(cols_n);
  assign ram_re    = cmd.accept || cmd.scr_rd;
  assign ram_raddr = cmd.accept ? AW'(in_cell_index) : src[AW-1:0];
  assign ram_we    = (cmd.exec_print && (char_r != NEWLINE_CODE))
                     || cmd.scr_move || cmd.zero_wr;
  assign ram_waddr = cmd.exec_print ? lin[AW-1:0] : ptr_r[AW-1:0];

  always_comb begin
    if (cmd.scr_move) begin
      ram_wdata = ram_rdata;
    end else if (cmd.exec_print) begin
      ram_wdata = {attr_r, char_r};
    end else begin
      ram_wdata = '0;
    end
  end

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (DEPTH)
  ) u_cell_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Result word
  assign rd_hit = (req_r == REQ_READ) && range_r;

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_row_r  <= CUR_ROW_W'(cur_row_nxt);
      out_col_r  <= CUR_COL_W'(cur_col_nxt);
      out_char_r <= rd_hit ? ram_rdata[CHAR_W-1:0] : '0;
      out_attr_r <= rd_hit ? ram_rdata[CELL_W-1:CHAR_W] : '0;
    end
  end

  assign out_cursor_row = out_row_r;
  assign out_cursor_col = out_col_r;
  assign out_read_char  = out_char_r;
  assign out_read_attr  = out_attr_r;

  // Status
  assign status.req          = req_r;
  assign status.needs_scroll = needs_scroll;
  assign status.move_more    = src < total_r;
  assign status.zero_last    = (ptr_r + PW'(1)) == total_r;
  assign status.clr_last     = ptr_r == PW'(DEPTH - 1);

endmodule

>>> rtl/tcw_checker.sv
// ----------------------------------------------------------------------------
// tcw_checker
// Port-level checks of the text console, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcw_checker import tcw_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [CUR_ROW_W-1:0]  out_cursor_row,
  input logic [CUR_COL_W-1:0]  out_cursor_col,
  input logic [CHAR_W-1:0]     out_read_char,
  input logic [ATTR_W-1:0]     out_read_attr
);

  // Stalled result word holds
  `TCW_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid, "result word dropped while stalled")

  `TCW_ASSERT_NXT(a_out_stable, out_valid && out_stall, $stable(out_cursor_row) && $stable(out_cursor_col) && $stable(out_read_char) && $stable(out_read_attr), "stalled result word changed")

  // One request at a time: busy right after a word is taken
  `TCW_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "second word taken before request done")

  // Reset starts the clearing pass with no result pending
  `TCW_ASSERT_NXT_ALL(a_reset_quiet, !rst_n, in_stall && !out_valid, "block not quiet after reset")

endmodule

bind text_console_writer_core tcw_checker u_tcw_checker (.*);
